FILE: rtl/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg: shared constants for the drum step sequencer
// Default geometry of the pattern and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package dss_pkg;

  // default geometry
  localparam int STEP_COUNT_DEF       = 32;
  localparam int INSTRUMENT_COUNT_DEF = 8;
  localparam int EDIT_STEPS_DEF       = 16;

  // front panel: step LEDs / buttons, and buttons usable for live hits
  localparam int LED_COUNT    = 16;
  localparam int LIVE_BUTTONS = 8;

  // field widths
  localparam int BUTTON_W   = 16;
  localparam int INST_SEL_W = 3;
  localparam int TRIG_W     = 8;
  localparam int LED_W      = 16;
  localparam int STEP_OUT_W = 5;

  // step position at or above which the second group LED lights
  localparam int SECOND_GROUP_STEP = 8;

endpackage

FILE: rtl/dss_pattern_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pattern_mem: pattern store
// One write port, one read port with registered read data. Per-entry valid
// flags, cleared by reset, make an entry that was never written read as zero.
// ----------------------------------------------------------------------------
module dss_pattern_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // valid flags and the flag of the entry being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: rtl/drum_step_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_step_sequencer: drum pattern step sequencer, one item per input poll
// Applies the edit action, tap/run/clock advance and the trigger flush to a
// pattern store held in a synchronous memory, and returns one result item.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------
//   in      | input     | in_valid_i / in_ready_o   | buttons, keys, run, clock
//   out     | output    | out_valid_o / out_ready_i | triggers, LEDs, step
//
// The sweep covers n entries (STEP_COUNT for a track clear, min(EDIT_STEPS,
// 16, STEP_COUNT) in edit mode, 0 otherwise) and reads and writes back one
// entry a cycle; a live record adds ST_LIVE_WR and a clocked gather adds
// ST_GATHER. Reset clears the store through its valid flags at once. A
// finished result waits in the output register without blocking the next
// item; a second one waits for out_ready_i.
// ----------------------------------------------------------------------------
module drum_step_sequencer #(
  parameter int STEP_COUNT       = dss_pkg::STEP_COUNT_DEF,
  parameter int INSTRUMENT_COUNT = dss_pkg::INSTRUMENT_COUNT_DEF,
  parameter int EDIT_STEPS       = dss_pkg::EDIT_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dss_pkg::BUTTON_W-1:0]   button_rise_mask_i,
  input  logic                           write_mode_held_i,
  input  logic                           clear_held_i,
  input  logic [dss_pkg::INST_SEL_W-1:0] instrument_select_i,
  input  logic                           run_on_i,
  input  logic                           run_edge_i,
  input  logic                           tap_rise_i,
  input  logic                           clock_pulse_i,
  input  logic                           beat_gate_i,
  input  logic                           flush_window_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           trigger_valid_o,
  output logic [dss_pkg::TRIG_W-1:0]     trigger_mask_o,
  output logic [dss_pkg::LED_W-1:0]      led_frame_o,
  output logic [dss_pkg::STEP_OUT_W-1:0] current_step_o,
  output logic                           second_group_led_o
);

  import dss_pkg::*;

  localparam int AW = $clog2(STEP_COUNT);
  localparam int CW = $clog2(STEP_COUNT + 1);
  localparam int IW = INSTRUMENT_COUNT;

  // steps reachable by edit view and toggling
  localparam int VIEW_A = (EDIT_STEPS < LED_COUNT) ? EDIT_STEPS : LED_COUNT;
  localparam int VIEW_N = (VIEW_A < STEP_COUNT) ? VIEW_A : STEP_COUNT;
  // buttons that name an instrument
  localparam int LIVE_N = (LIVE_BUTTONS < IW) ? LIVE_BUTTONS : IW;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SWEEP   = 3'd1;
  localparam logic [2:0] ST_LIVE_RD = 3'd2;
  localparam logic [2:0] ST_LIVE_WR = 3'd3;
  localparam logic [2:0] ST_ADV     = 3'd4;
  localparam logic [2:0] ST_GATHER  = 3'd5;
  localparam logic [2:0] ST_FIN     = 3'd6;

  function automatic logic [AW-1:0] step_next(input logic [AW-1:0] s);
    return (32'(s) == STEP_COUNT - 1) ? '0 : s + 1'b1;
  endfunction

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         wr_idx_q, wr_idx_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [LED_W-1:0]      led_q, led_d;

  // captured item
  logic [BUTTON_W-1:0]   btn_q;
  logic                  edit_q, clr_q, run_q, run_edge_q, tap_q, pulse_q, gate_q, flush_q;
  logic [INST_SEL_W-1:0] inst_q;

  // sequencer state
  logic [AW-1:0]         step_q, step_d;
  logic                  restart_q, restart_d;
  logic [IW-1:0]         gathered_q, gathered_d;
  logic                  pending_q, pending_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  trig_valid_q, trig_valid_d;
  logic [TRIG_W-1:0]     trig_mask_q, trig_mask_d;
  logic [LED_W-1:0]      led_out_q, led_out_d;
  logic [AW-1:0]         step_out_q, step_out_d;
  logic                  out_load;

  // memory port
  logic                  mem_rd_en, mem_wr_en;
  logic [AW-1:0]         mem_rd_addr, mem_wr_addr;
  logic [IW-1:0]         mem_rd_data, mem_wr_data;

  // per-item derived values
  logic [IW-1:0]         inst_bit, live_bits, swept_data;
  logic [CW-1:0]         sweep_n;
  logic [AW-1:0]         target, adv_step;
  logic                  adv_restart, btn_hit;
  logic [LED_W-1:0]      led_view, led_step;

  logic in_accept;
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // selected instrument bit and live/clear button bits
  always_comb begin
    inst_bit  = (32'(inst_q) < IW) ? (IW'(1) << inst_q) : '0;
    live_bits = '0;
    for (int i = 0; i < IW; i++) begin
      if (i < LIVE_N) begin
        live_bits[i] = btn_q[i];
      end
    end
  end

  assign sweep_n = clr_q ? CW'(STEP_COUNT) : (edit_q ? CW'(VIEW_N) : '0);
  assign target  = (!run_q || gate_q) ? step_q : step_next(step_q);

  // button and edit view LED of the entry coming out of the memory
  always_comb begin
    btn_hit  = 1'b0;
    led_view = '0;
    for (int j = 0; j < LED_COUNT; j++) begin
      if (j < VIEW_N && 32'(wr_idx_q) == j) begin
        btn_hit     = btn_q[j];
        led_view[j] = edit_q && ((mem_rd_data & inst_bit) != '0);
      end
    end
  end

  assign swept_data = clr_q ? (mem_rd_data & ~live_bits)
                            : (btn_hit ? (mem_rd_data ^ inst_bit) : mem_rd_data);

  // tap, run edge and clocked advance
  always_comb begin
    adv_step    = step_q;
    adv_restart = restart_q;
    if (tap_q) begin
      adv_step = step_next(adv_step);
    end
    if (run_edge_q) begin
      adv_step    = '0;
      adv_restart = 1'b1;
    end
    if (pulse_q && run_q) begin
      if (adv_restart) begin
        adv_restart = 1'b0;
      end else begin
        adv_step = step_next(adv_step);
      end
    end
  end

  // current step LED on the gate
  always_comb begin
    led_step = '0;
    for (int j = 0; j < LED_COUNT; j++) begin
      if (gate_q && 32'(step_q) == j) begin
        led_step[j] = 1'b1;
      end
    end
  end

  assign out_load = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    wr_idx_d     = wr_idx_q;
    rd_pend_d    = 1'b0;
    led_d        = led_q;
    step_d       = step_q;
    restart_d    = restart_q;
    gathered_d   = gathered_q;
    pending_d    = pending_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    trig_valid_d = trig_valid_q;
    trig_mask_d  = trig_mask_q;
    led_out_d    = led_out_q;
    step_out_d   = step_out_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = '0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = wr_idx_q;
    mem_wr_data  = swept_data;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cnt_d   = '0;
          led_d   = '0;
          state_d = ST_SWEEP;
        end
      end
      // one entry read and the previous one written back each cycle
      ST_SWEEP: begin
        if (rd_pend_q) begin
          mem_wr_en = 1'b1;
          led_d     = led_q | led_view;
        end
        if (cnt_q < sweep_n) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cnt_q[AW-1:0];
          wr_idx_d    = cnt_q[AW-1:0];
          rd_pend_d   = 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          state_d = ST_LIVE_RD;
        end
      end
      ST_LIVE_RD: begin
        if (!clr_q && !edit_q && live_bits != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = target;
          state_d     = ST_LIVE_WR;
        end else begin
          state_d = ST_ADV;
        end
      end
      // live record into the target step
      ST_LIVE_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = target;
        mem_wr_data = mem_rd_data | live_bits;
        gathered_d  = gathered_q | live_bits;
        pending_d   = 1'b1;
        state_d     = ST_ADV;
      end
      ST_ADV: begin
        step_d    = adv_step;
        restart_d = adv_restart;
        if (pulse_q && run_q) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = adv_step;
          state_d     = ST_GATHER;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_GATHER: begin
        gathered_d = gathered_q | mem_rd_data;
        pending_d  = 1'b1;
        state_d    = ST_FIN;
      end
      // flush and load the result once the output register is free
      ST_FIN: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          led_out_d    = led_q | led_step;
          step_out_d   = step_q;
          trig_valid_d = flush_q && pending_q;
          trig_mask_d  = '0;
          if (flush_q && pending_q) begin
            trig_mask_d = TRIG_W'(gathered_q);
            gathered_d  = '0;
            pending_d   = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      step_q      <= '0;
      restart_q   <= 1'b0;
      gathered_q  <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      step_q      <= step_d;
      restart_q   <= restart_d;
      gathered_q  <= gathered_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      btn_q      <= button_rise_mask_i;
      edit_q     <= write_mode_held_i;
      clr_q      <= clear_held_i;
      inst_q     <= instrument_select_i;
      run_q      <= run_on_i;
      run_edge_q <= run_edge_i;
      tap_q      <= tap_rise_i;
      pulse_q    <= clock_pulse_i;
      gate_q     <= beat_gate_i;
      flush_q    <= flush_window_i;
    end
    wr_idx_q     <= wr_idx_d;
    led_q        <= led_d;
    trig_valid_q <= trig_valid_d;
    trig_mask_q  <= trig_mask_d;
    led_out_q    <= led_out_d;
    step_out_q   <= step_out_d;
  end

  dss_pattern_mem #(
    .DEPTH (STEP_COUNT),
    .WIDTH (IW),
    .AW    (AW)
  ) u_pattern_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  assign out_valid_o        = out_valid_q;
  assign trigger_valid_o    = trig_valid_q;
  assign trigger_mask_o     = trig_mask_q;
  assign led_frame_o        = led_out_q;
  assign current_step_o     = STEP_OUT_W'(step_out_q);
  assign second_group_led_o = (32'(step_out_q) >= SECOND_GROUP_STEP);

endmodule

FILE: tb/tb_drum_step_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drum_step_sequencer: self-checking bench for the drum step sequencer
// Sends poll items through the input handshake and keeps a behavioral copy
// of the pattern, step and trigger state. Every returned item is compared
// field by field with the oldest predicted one. Directed tests cover the
// edit actions and the transport; random polls with random idling on both
// sides, a long output hold-off and a drain pause cover the rest.
// ----------------------------------------------------------------------------
module tb_drum_step_sequencer;
  import dss_pkg::*;

  localparam int STEPS     = STEP_COUNT_DEF;
  localparam int INSTS     = INSTRUMENT_COUNT_DEF;
  localparam int EDITS     = EDIT_STEPS_DEF;
  // steps reachable from the buttons in edit mode, buttons usable for hits
  localparam int EDIT_SPAN = (EDITS < LED_COUNT) ? ((EDITS < STEPS) ? EDITS : STEPS)
                                                 : ((LED_COUNT < STEPS) ? LED_COUNT : STEPS);
  localparam int HIT_SPAN  = (LIVE_BUTTONS < INSTS) ? LIVE_BUTTONS : INSTS;

  typedef struct packed {
    logic [BUTTON_W-1:0]   buttons;
    logic                  edit;
    logic                  clr;
    logic [INST_SEL_W-1:0] inst;
    logic                  run;
    logic                  run_edge;
    logic                  tap;
    logic                  pulse;
    logic                  gate;
    logic                  flush;
  } poll_t;

  typedef struct packed {
    logic                  fire;
    logic [TRIG_W-1:0]     mask;
    logic [LED_W-1:0]      leds;
    logic [STEP_OUT_W-1:0] step;
    logic                  grp;
  } beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [BUTTON_W-1:0]   button_rise_mask_i;
  logic                  write_mode_held_i;
  logic                  clear_held_i;
  logic [INST_SEL_W-1:0] instrument_select_i;
  logic                  run_on_i;
  logic                  run_edge_i;
  logic                  tap_rise_i;
  logic                  clock_pulse_i;
  logic                  beat_gate_i;
  logic                  flush_window_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  trigger_valid_o;
  logic [TRIG_W-1:0]     trigger_mask_o;
  logic [LED_W-1:0]      led_frame_o;
  logic [STEP_OUT_W-1:0] current_step_o;
  logic                  second_group_led_o;

  // predicted sequencer state
  logic [TRIG_W-1:0] pat_mem [STEPS];
  int                step_pos;
  logic              restart_armed;
  logic [TRIG_W-1:0] gathered;
  logic              trig_armed;

  beat_t expected_beats[$];
  beat_t want;
  int    mismatches;
  bit    tx_idle;
  bit    rx_idle;
  int    rx_hold_cycles;

  drum_step_sequencer #(
    .STEP_COUNT      (STEPS),
    .INSTRUMENT_COUNT(INSTS),
    .EDIT_STEPS      (EDITS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .button_rise_mask_i (button_rise_mask_i),
    .write_mode_held_i  (write_mode_held_i),
    .clear_held_i       (clear_held_i),
    .instrument_select_i(instrument_select_i),
    .run_on_i           (run_on_i),
    .run_edge_i         (run_edge_i),
    .tap_rise_i         (tap_rise_i),
    .clock_pulse_i      (clock_pulse_i),
    .beat_gate_i        (beat_gate_i),
    .flush_window_i     (flush_window_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .trigger_valid_o    (trigger_valid_o),
    .trigger_mask_o     (trigger_mask_o),
    .led_frame_o        (led_frame_o),
    .current_step_o     (current_step_o),
    .second_group_led_o (second_group_led_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the handshake hangs
  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one poll applied to the predicted state; returns the item it yields
  function automatic beat_t predict_beat(poll_t p);
    beat_t             r;
    logic [TRIG_W-1:0] inst_bit;
    logic [LED_W-1:0]  leds;
    int                tgt;
    inst_bit = (int'(p.inst) < INSTS) ? (TRIG_W'(1) << p.inst) : '0;
    tgt      = (!p.run || p.gate) ? step_pos : (step_pos + 1) % STEPS;
    leds     = '0;

    // edit view reflects the store before this poll's edit
    if (p.edit)
      for (int i = 0; i < EDIT_SPAN; i++)
        leds[i] = |(pat_mem[i] & inst_bit);

    if (p.clr) begin
      for (int i = 0; i < HIT_SPAN; i++)
        if (p.buttons[i])
          for (int s = 0; s < STEPS; s++) pat_mem[s][i] = 1'b0;
    end else if (p.edit) begin
      for (int i = 0; i < EDIT_SPAN; i++)
        if (p.buttons[i]) pat_mem[i] = pat_mem[i] ^ inst_bit;
    end else begin
      // live hits land on the current or the upcoming step
      for (int i = 0; i < HIT_SPAN; i++)
        if (p.buttons[i]) begin
          gathered[i]     = 1'b1;
          pat_mem[tgt][i] = 1'b1;
          trig_armed      = 1'b1;
        end
    end

    if (p.tap) step_pos = (step_pos + 1) % STEPS;
    if (p.run_edge) begin
      step_pos      = 0;
      restart_armed = 1'b1;
    end

    // clocked advance; the first pulse after a restart does not advance the step
    if (p.pulse && p.run) begin
      if (restart_armed) restart_armed = 1'b0;
      else step_pos = (step_pos + 1) % STEPS;
      gathered   = gathered | pat_mem[step_pos];
      trig_armed = 1'b1;
    end

    if (p.gate && step_pos < LED_COUNT) leds[step_pos] = 1'b1;

    r.fire = 1'b0;
    r.mask = '0;
    if (p.flush && trig_armed) begin
      r.fire     = 1'b1;
      r.mask     = gathered;
      gathered   = '0;
      trig_armed = 1'b0;
    end
    r.leds = leds;
    r.step = STEP_OUT_W'(step_pos);
    r.grp  = (step_pos >= SECOND_GROUP_STEP);
    return r;
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    int    mode;
    int    pick;
    mode = $urandom_range(0, 99);
    pick = $urandom_range(0, 3);
    case (pick)
      0:       p.buttons = '0;
      1:       p.buttons = BUTTON_W'(1) << $urandom_range(0, BUTTON_W - 1);
      2:       p.buttons = BUTTON_W'($urandom);
      default: p.buttons = BUTTON_W'($urandom & $urandom & $urandom);
    endcase
    // track clears are rare so the store keeps some content
    p.clr      = (mode < 6);
    p.edit     = (mode < 6) ? 1'($urandom_range(0, 1)) : (mode < 35);
    p.inst     = INST_SEL_W'($urandom_range(0, 7));
    p.run      = ($urandom_range(0, 99) < 75);
    p.run_edge = ($urandom_range(0, 99) < 3);
    p.tap      = ($urandom_range(0, 99) < 12);
    p.pulse    = ($urandom_range(0, 99) < 45);
    p.gate     = ($urandom_range(0, 99) < 50);
    p.flush    = ($urandom_range(0, 99) < 35);
    return p;
  endfunction

  // offer one item, predict it once accepted, then maybe idle
  task automatic send_poll(input poll_t p);
    int gap;
    @(negedge clk_i);
    button_rise_mask_i  <= p.buttons;
    write_mode_held_i   <= p.edit;
    clear_held_i        <= p.clr;
    instrument_select_i <= p.inst;
    run_on_i            <= p.run;
    run_edge_i          <= p.run_edge;
    tap_rise_i          <= p.tap;
    clock_pulse_i       <= p.pulse;
    beat_gate_i         <= p.gate;
    flush_window_i      <= p.flush;
    in_valid_i          <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_beats.push_back(predict_beat(p));
    gap = tx_idle ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // live hits with run off, run on between beats, empty flush
  task automatic test_live_record();
    poll_t p;
    p = '0; p.buttons = 16'hFFFF; p.flush = 1'b1;
    send_poll(p);
    p = '0; p.run = 1'b1; p.buttons = 16'h0008;
    send_poll(p);
    p = '0; p.flush = 1'b1; p.gate = 1'b1;
    send_poll(p);
    p = '0; p.flush = 1'b1;
    send_poll(p);
  endtask

  // toggling every edit step, view of first and last instrument
  task automatic test_edit_toggle();
    poll_t p;
    p = '0; p.edit = 1'b1; p.buttons = 16'hFFFF;
    send_poll(p);
    p = '0; p.edit = 1'b1;
    send_poll(p);
    p = '0; p.edit = 1'b1; p.inst = 3'd7; p.buttons = 16'h8001;
    send_poll(p);
    p = '0; p.edit = 1'b1; p.inst = 3'd3; p.gate = 1'b1;
    send_poll(p);
  endtask

  // clearing one track, upper buttons ignored, then all tracks
  task automatic test_track_clear();
    poll_t p;
    p = '0; p.clr = 1'b1; p.edit = 1'b1; p.buttons = 16'hFF01;
    send_poll(p);
    p = '0; p.edit = 1'b1;
    send_poll(p);
    p = '0; p.clr = 1'b1; p.buttons = 16'h00FF;
    send_poll(p);
    p = '0; p.edit = 1'b1; p.inst = 3'd7;
    send_poll(p);
  endtask

  // tap, pulse with run off, restart on run edge, walk past steps 8 and 16
  task automatic test_transport();
    poll_t p;
    p = '0; p.tap = 1'b1;
    send_poll(p);
    p = '0; p.pulse = 1'b1;
    send_poll(p);
    p = '0; p.run = 1'b1; p.run_edge = 1'b1;
    send_poll(p);
    p = '0; p.run = 1'b1; p.pulse = 1'b1; p.flush = 1'b1;
    send_poll(p);
    for (int k = 0; k < 9; k++) begin
      p = '0; p.run = 1'b1; p.tap = 1'b1; p.pulse = 1'b1; p.gate = 1'b1; p.flush = 1'b1;
      p.buttons = BUTTON_W'(1) << (k % LIVE_BUTTONS);
      send_poll(p);
    end
  endtask

  task automatic test_random_polls(input int count);
    for (int k = 0; k < count; k++) begin
      // switch idling on and off in stretches
      if (k % 100 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      send_poll(random_poll());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // sink holds off while the source keeps offering back to back
  task automatic test_output_backpressure();
    tx_idle        = 1'b0;
    rx_hold_cycles = 250;
    repeat (10) send_poll(random_poll());
    tx_idle = 1'b1;
  endtask

  // source stops until every result is back, then resumes
  task automatic test_sender_pause();
    wait_drained();
    repeat (20) send_poll(random_poll());
  endtask

  // output sink: random ready with long hold-offs on request
  initial begin : sink
    int   run_left;
    logic level;
    out_ready_i = 1'b0;
    run_left    = 0;
    level       = 1'b1;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else if (!rx_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          level    = !level;
          run_left = level ? $urandom_range(1, 16) : idle_len();
          if (run_left == 0) begin
            level    = 1'b1;
            run_left = $urandom_range(1, 16);
          end
        end
        out_ready_i <= level;
        run_left--;
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result item with nothing outstanding", $time);
      end else begin
        want = expected_beats.pop_front();
        if (trigger_valid_o !== want.fire || trigger_mask_o !== want.mask ||
            led_frame_o !== want.leds || current_step_o !== want.step ||
            second_group_led_o !== want.grp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp fire=%0b mask=%h led=%h step=%0d grp=%0b",
                     $time, want.fire, want.mask, want.leds, want.step, want.grp,
                     " got fire=%0b mask=%h led=%h step=%0d grp=%0b",
                     trigger_valid_o, trigger_mask_o, led_frame_o, current_step_o,
                     second_group_led_o);
        end
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    button_rise_mask_i  = '0;
    write_mode_held_i   = 1'b0;
    clear_held_i        = 1'b0;
    instrument_select_i = '0;
    run_on_i            = 1'b0;
    run_edge_i          = 1'b0;
    tap_rise_i          = 1'b0;
    clock_pulse_i       = 1'b0;
    beat_gate_i         = 1'b0;
    flush_window_i      = 1'b0;
    mismatches          = 0;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    rx_hold_cycles      = 0;
    for (int s = 0; s < STEPS; s++) pat_mem[s] = '0;
    step_pos      = 0;
    restart_armed = 1'b0;
    gathered      = '0;
    trig_armed    = 1'b0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_live_record();
    test_edit_toggle();
    test_track_clear();
    test_transport();
    test_random_polls(650);
    test_output_backpressure();
    test_sender_pause();
    test_random_polls(700);

    // drain, then watch for stray items
    wait_drained();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
rtl/dss_pkg.sv
rtl/dss_pattern_mem.sv
rtl/drum_step_sequencer.sv
tb/tb_drum_step_sequencer.sv
